>>> hw/rtl/btmx_pkg.sv
// Shared types and constants for the binary trie maximum-XOR block.
`default_nettype none

package btmx_pkg;

  // Fixed field widths of the item and result payloads.
  localparam int KEY_W    = 31;
  localparam int STATUS_W = 2;

  // What an item asks the trie to do.
  typedef enum logic [0:0] {
    KIND_INSERT = 1'b0,
    KIND_QUERY  = 1'b1
  } kind_t;

  // Outcome reported with every result.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  // Input item payload.
  typedef struct packed {
    kind_t              kind;
    logic [KEY_W-1:0]   key;
  } item_t;

  // Result item payload.
  typedef struct packed {
    logic [KEY_W-1:0]   best_xor;
    status_t            status;
  } result_t;

  // Handshake between the walker and the output stage.
  typedef struct packed {
    logic    idle;
    logic    res_valid;
    result_t res;
  } walk_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/btmx_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module btmx_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 32768
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/btmx_walk.sv
// Trie walker: shifts the key out one bit per cycle and steps one trie level per bit.
`default_nettype none

module btmx_walk #(
  parameter int KEY_BITS   = 31,
  parameter int NODE_COUNT = 32768
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire btmx_pkg::item_t       item,
  input  wire logic                  res_take,
  output btmx_pkg::walk_status_t     stat
);

  localparam int NODE_W  = $clog2(NODE_COUNT);
  localparam int NU_W    = $clog2(NODE_COUNT + 1);
  localparam int LVL_W   = $clog2(KEY_BITS + 1);
  localparam int FULL_AT = NODE_COUNT - KEY_BITS;

  // One-hot walk sequencer.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WALK = 4'b0010,
    S_SEAL = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t                state, state_next;
  logic                  is_query, is_query_next;
  logic [KEY_BITS-1:0]   ksh, ksh_next;
  logic [KEY_BITS-1:0]   best, best_next;
  logic [LVL_W-1:0]      lvl_left, lvl_left_next;
  logic [NODE_W-1:0]     node, node_next;
  logic                  fresh, fresh_next;
  logic                  dead, dead_next;
  btmx_pkg::status_t     status, status_next;
  logic [NU_W-1:0]       nodes_used, nodes_used_next;
  logic                  keys_stored, keys_stored_next;
  logic [NODE_W-1:0]     root_zero, root_zero_next;
  logic [NODE_W-1:0]     root_one, root_one_next;

  logic                  zwe, owe;
  logic [NODE_W-1:0]     zwa, owa, zwd, owd;
  logic [NODE_W-1:0]     zrd, ord;

  logic [31:0]           key32;
  logic [31:0]           best32;
  logic                  kbit;
  logic [NODE_W-1:0]     zc, oc, link_same, link_opp, nu_node;
  logic                  xbit;

  // Child link stores, one per side, addressed by node.
  btmx_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_zero_ram (
    .clk     (clk),
    .we      (zwe),
    .wr_addr (zwa),
    .wr_data (zwd),
    .rd_addr (node_next),
    .rd_data (zrd)
  );

  btmx_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_one_ram (
    .clk     (clk),
    .we      (owe),
    .wr_addr (owa),
    .wr_data (owd),
    .rd_addr (node_next),
    .rd_data (ord)
  );

  // The root's links live in registers; every other node's links come from the stores.
  assign key32     = {1'b0, item.key};
  assign kbit      = ksh[KEY_BITS-1];
  assign zc        = (node == '0) ? root_zero : zrd;
  assign oc        = (node == '0) ? root_one  : ord;
  assign link_same = kbit ? oc : zc;
  assign link_opp  = kbit ? zc : oc;
  assign nu_node   = nodes_used[NODE_W-1:0];

  // Next-state logic for the sequencer and the walk datapath.
  always_comb begin
    state_next       = state;
    is_query_next    = is_query;
    ksh_next         = ksh;
    best_next        = best;
    lvl_left_next    = lvl_left;
    node_next        = node;
    fresh_next       = fresh;
    dead_next        = dead;
    status_next      = status;
    nodes_used_next  = nodes_used;
    keys_stored_next = keys_stored;
    root_zero_next   = root_zero;
    root_one_next    = root_one;
    zwe              = 1'b0;
    owe              = 1'b0;
    zwa              = node;
    owa              = node;
    zwd              = '0;
    owd              = '0;
    xbit             = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          is_query_next = (item.kind == btmx_pkg::KIND_QUERY);
          ksh_next      = key32[KEY_BITS-1:0];
          best_next     = '0;
          lvl_left_next = LVL_W'(KEY_BITS);
          node_next     = '0;
          fresh_next    = 1'b0;
          dead_next     = 1'b0;
          status_next   = btmx_pkg::STATUS_OK;
          if (item.kind == btmx_pkg::KIND_QUERY) begin
            if (!keys_stored) begin
              status_next = btmx_pkg::STATUS_EMPTY;
              state_next  = S_DONE;
            end else begin
              state_next = S_WALK;
            end
          end else begin
            if (nodes_used > NU_W'(FULL_AT)) begin
              status_next = btmx_pkg::STATUS_FULL;
              state_next  = S_DONE;
            end else begin
              keys_stored_next = 1'b1;
              state_next       = S_WALK;
            end
          end
        end
      end

      S_WALK: begin
        if (is_query) begin
          // Prefer the child opposite to the key bit; a missing path ends the match.
          if (!dead) begin
            if (link_opp != '0) begin
              xbit      = 1'b1;
              node_next = link_opp;
            end else if (link_same != '0) begin
              node_next = link_same;
            end else begin
              dead_next = 1'b1;
            end
          end
        end else if (fresh) begin
          // A new node gets both links written at once: one to the next new node.
          zwe             = 1'b1;
          owe             = 1'b1;
          zwd             = kbit ? '0 : nu_node;
          owd             = kbit ? nu_node : '0;
          node_next       = nu_node;
          nodes_used_next = nodes_used + NU_W'(1);
        end else if (link_same != '0) begin
          node_next = link_same;
        end else begin
          // First missing child: hang a new node off an existing one.
          if (node == '0) begin
            if (kbit) begin
              root_one_next = nu_node;
            end else begin
              root_zero_next = nu_node;
            end
          end else if (kbit) begin
            owe = 1'b1;
            owd = nu_node;
          end else begin
            zwe = 1'b1;
            zwd = nu_node;
          end
          node_next       = nu_node;
          nodes_used_next = nodes_used + NU_W'(1);
          fresh_next      = 1'b1;
        end

        ksh_next      = ksh << 1;
        best_next     = (best << 1) | KEY_BITS'(xbit);
        lvl_left_next = lvl_left - LVL_W'(1);
        if (lvl_left == LVL_W'(1)) begin
          state_next = (!is_query && fresh_next) ? S_SEAL : S_DONE;
        end
      end

      S_SEAL: begin
        // The new leaf has no children.
        zwe        = 1'b1;
        owe        = 1'b1;
        state_next = S_DONE;
      end

      S_DONE: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state with reset; datapath registers without.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      nodes_used  <= NU_W'(1);
      keys_stored <= 1'b0;
      root_zero   <= '0;
      root_one    <= '0;
    end else begin
      state       <= state_next;
      nodes_used  <= nodes_used_next;
      keys_stored <= keys_stored_next;
      root_zero   <= root_zero_next;
      root_one    <= root_one_next;
    end
    is_query <= is_query_next;
    ksh      <= ksh_next;
    best     <= best_next;
    lvl_left <= lvl_left_next;
    node     <= node_next;
    fresh    <= fresh_next;
    dead     <= dead_next;
    status   <= status_next;
  end

  // Result and status toward the output stage.
  assign best32              = 32'(best);
  assign stat.idle           = (state == S_IDLE);
  assign stat.res_valid      = (state == S_DONE);
  assign stat.res.best_xor   = best32[btmx_pkg::KEY_W-1:0];
  assign stat.res.status     = status;

endmodule

`default_nettype wire

>>> hw/rtl/binary_trie_max_xor.sv
// Binary trie maximum-XOR engine: one insert or query per item, one trie level per cycle.
// A walk that allocates nodes passes through S_WALK, S_SEAL and S_DONE; any other walk through
// S_WALK and S_DONE; an empty-trie query or a refused insert goes from S_IDLE straight to S_DONE.
// One item at a time: a new item is taken only once the walker has handed its result to the
// output register and returned to S_IDLE; each level is one dependent link read.
// Reset clears the root links, the node count (one, the root) and the stored-key flag.
`default_nettype none

module binary_trie_max_xor #(
  parameter int KEY_BITS   = 31,
  parameter int NODE_COUNT = 32768
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_stall,
  input  wire btmx_pkg::item_t    item,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output btmx_pkg::result_t       result
);

  btmx_pkg::walk_status_t stat;
  logic                   start;
  logic                   res_take;

  // Take an item whenever the walker is free.
  assign item_stall = !stat.idle;
  assign start      = item_valid && !item_stall;

  btmx_walk #(.KEY_BITS(KEY_BITS), .NODE_COUNT(NODE_COUNT)) u_walk (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .item     (item),
    .res_take (res_take),
    .stat     (stat)
  );

  // Output register: loads when empty or when its result transfers out.
  assign res_take = stat.res_valid && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (res_take) begin
      result <= stat.res;
    end
  end

endmodule

`default_nettype wire

>>> tb/trie_result_checker.sv
// Checker that predicts every trie result from the accepted items and compares it field by field.
`timescale 1ns / 1ps

module trie_result_checker
  import btmx_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  logic    item_stall,
  input  item_t   item,
  input  logic    result_valid,
  input  logic    result_stall,
  input  result_t result,
  output int      errors,
  output int      pending
);

  localparam int NODES       = 32768;
  localparam int LINK_W      = 15;
  localparam int PRINT_LIMIT = 200;

  // A predicted result kept together with the item that caused it.
  typedef struct packed {
    item_t   src;
    result_t res;
  } predicted_t;

  // Shadow copy of the node store and its bookkeeping.
  bit [LINK_W-1:0] zero_link [NODES];
  bit [LINK_W-1:0] one_link  [NODES];
  logic [15:0]     nodes_used;
  logic            keys_stored;

  predicted_t predicted_results[$];

  // Prints one line per mismatch, up to a limit, and counts every one.
  task automatic report_mismatch(input string what);
    if (errors < PRINT_LIMIT) begin
      $display("%0t trie check: %s", $realtime, what);
    end
    errors = errors + 1;
  endtask

  // Applies one item to the shadow trie and returns the result it should produce.
  function automatic result_t walk_trie(input item_t it);
    result_t         r;
    logic [LINK_W-1:0] node;
    logic [LINK_W-1:0] nx;
    logic [LINK_W-1:0] want;
    logic            b;
    r.best_xor = '0;
    r.status   = STATUS_OK;
    node       = '0;
    if (it.kind == KIND_INSERT) begin
      // An insert needs room for a full path, even when the key is already present.
      if (NODES - nodes_used < KEY_W) begin
        r.status = STATUS_FULL;
      end else begin
        for (int lvl = KEY_W - 1; lvl >= 0; lvl--) begin
          b  = it.key[lvl];
          nx = b ? one_link[node] : zero_link[node];
          if (nx == '0) begin
            nx            = nodes_used[LINK_W-1:0];
            nodes_used    = nodes_used + 16'd1;
            zero_link[nx] = '0;
            one_link[nx]  = '0;
            if (b) begin
              one_link[node] = nx;
            end else begin
              zero_link[node] = nx;
            end
          end
          node = nx;
        end
        keys_stored = 1'b1;
      end
    end else if (!keys_stored) begin
      r.status = STATUS_EMPTY;
    end else begin
      // Take the opposite branch wherever it exists; that bit of the XOR is then set.
      for (int lvl = KEY_W - 1; lvl >= 0; lvl--) begin
        b    = it.key[lvl];
        want = b ? zero_link[node] : one_link[node];
        if (want != '0) begin
          r.best_xor[lvl] = 1'b1;
          node            = want;
        end else begin
          node = b ? one_link[node] : zero_link[node];
          if (node == '0) break;
        end
      end
    end
    return r;
  endfunction

  // Predict on each item transfer and compare on each result transfer.
  always @(posedge clk) begin
    predicted_t p;
    if (rst) begin
      zero_link[0] = '0;
      one_link[0]  = '0;
      nodes_used   = 16'd1;
      keys_stored  = 1'b0;
      predicted_results.delete();
    end else begin
      if (item_valid && !item_stall) begin
        p.src = item;
        p.res = walk_trie(item);
        predicted_results.push_back(p);
      end
      if (result_valid && !result_stall) begin
        if (predicted_results.size() == 0) begin
          report_mismatch($sformatf("result %h/%0d arrived with nothing outstanding",
                                    result.best_xor, result.status));
        end else begin
          p = predicted_results.pop_front();
          if (result.best_xor !== p.res.best_xor) begin
            report_mismatch($sformatf("kind %0d key %h: best_xor %h, predicted %h",
                                      p.src.kind, p.src.key, result.best_xor,
                                      p.res.best_xor));
          end
          if (result.status !== p.res.status) begin
            report_mismatch($sformatf("kind %0d key %h: status %0d, predicted %0d",
                                      p.src.kind, p.src.key, result.status,
                                      p.res.status));
          end
        end
      end
    end
    pending <= predicted_results.size();
  end

endmodule

>>> tb/testbench.sv
// Top of the trie maximum-XOR testbench: clock, reset, stimulus, result stalls and verdict.
`timescale 1ns / 1ps

module testbench;

  import btmx_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  logic    item_stall;
  item_t   item         = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;
  int mismatches;
  int pending;

  logic [KEY_W-1:0] inserted_keys[$];

  binary_trie_max_xor i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  trie_result_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .errors       (mismatches),
    .pending      (pending)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // The result side stalls at random, independent of result_valid.
  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog: ends the run when no transfer happens on either side for too long.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("binary_trie_max_xor: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Presents one item after a random gap and holds it until the transfer happens.
  task automatic send_op(input kind_t kind, input logic [KEY_W-1:0] key);
    item_t it;
    it.kind = kind;
    it.key  = key;
    if (kind == KIND_INSERT) begin
      inserted_keys.push_back(key);
    end
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  // Keys are random at least half the time, with small values, near-maximum values, stored keys
  // and stored keys with one bit flipped mixed in.
  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] k;
    k = KEY_W'($urandom);
    case ($urandom_range(7))
      0: k = KEY_W'($urandom_range(15));
      1: k = ~KEY_W'($urandom_range(15));
      2: begin
        if (inserted_keys.size() != 0) begin
          k = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
        end
      end
      3: begin
        if (inserted_keys.size() != 0) begin
          k = inserted_keys[$urandom_range(inserted_keys.size() - 1)]
              ^ (KEY_W'(1) << $urandom_range(KEY_W - 1));
        end
      end
      default: ;
    endcase
    return k;
  endfunction

  task automatic send_random(input int insert_pct);
    if ($urandom_range(99) < insert_pct) begin
      send_op(KIND_INSERT, pick_key());
    end else begin
      send_op(KIND_QUERY, pick_key());
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Sender idles often, receiver stalls more.
    send_idle_pct  = 27;
    recv_stall_pct = 60;

    // Queries on the empty trie, then the key extremes, duplicates and alternating patterns.
    send_op(KIND_QUERY,  31'h0000_0000);
    send_op(KIND_QUERY,  31'h7FFF_FFFF);
    send_op(KIND_INSERT, 31'h0000_0000);
    send_op(KIND_QUERY,  31'h0000_0000);
    send_op(KIND_QUERY,  31'h7FFF_FFFF);
    send_op(KIND_INSERT, 31'h0000_0000);
    send_op(KIND_INSERT, 31'h7FFF_FFFF);
    send_op(KIND_QUERY,  31'h0000_0000);
    send_op(KIND_QUERY,  31'h7FFF_FFFF);
    send_op(KIND_QUERY,  31'h2AAA_AAAA);
    send_op(KIND_QUERY,  31'h5555_5555);
    send_op(KIND_INSERT, 31'h5555_5555);
    send_op(KIND_INSERT, 31'h2AAA_AAAA);
    send_op(KIND_QUERY,  31'h5555_5555);
    send_op(KIND_QUERY,  31'h4000_0000);
    send_op(KIND_QUERY,  31'h3FFF_FFFF);
    send_op(KIND_INSERT, 31'h0000_0001);
    send_op(KIND_INSERT, 31'h4000_0000);
    send_op(KIND_QUERY,  31'h0000_0001);
    send_op(KIND_QUERY,  31'h7FFF_FFFE);
    send_op(KIND_INSERT, 31'h0000_0001);

    repeat (275) send_random(50);

    // Sender idles more, receiver stalls less.
    send_idle_pct  = 60;
    recv_stall_pct = 27;
    repeat (275) send_random(50);

    // No idling on either side, with inserts in the majority.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (280) send_random(70);

    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("binary_trie_max_xor: match");
    end else begin
      $display("binary_trie_max_xor: mismatch");
    end
    $finish;
  end

endmodule
